>>> src/idw_pkg.sv
// Package for the four-nearest IDW table interpolator.
// Shared types and constants; no dependencies.
package idw_pkg;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned SqW     = 50;
  localparam int unsigned DistW   = 25;
  localparam int unsigned WeightW = 37;
  localparam int unsigned NumW    = 63;
  localparam int unsigned MaxPick = 4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic start_query;
    logic bounds_step;
    logic dist_step;
    logic final_step;
    logic sqrt_start;
    logic div_start;
    logic wdiv_start;
    logic accum_step;
  } idw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic exact;
    logic sqrt_done;
    logic div_done;
    logic last_pick;
  } idw_stat_t;
endpackage

>>> src/idw_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
module idw_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/idw_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// No dependencies.
module idw_divider #(
  parameter int unsigned NumBits = 64,
  parameter int unsigned DenBits = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumBits + 1);
  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> src/idw_sqrt.sv
// Bit-pair serial integer square root, one result bit per cycle.
// No dependencies.
module idw_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] val_i,
  output logic        done_o,
  output logic [24:0] root_o
);
  logic [49:0] rad_q;
  logic [26:0] rem_q;
  logic [24:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [26:0] trial, shifted;

  assign shifted = {rem_q[24:0], rad_q[49:48]};
  assign trial   = shifted - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd24;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[47:0], 2'b00};
      if (!trial[26]) begin
        rem_q  <= trial;
        root_q <= {root_q[23:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        root_q <= {root_q[23:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> src/idw_datapath.sv
// Datapath: row memories, bounds and distance scans, top-four selection,
// weight and mean arithmetic. Depends on idw_pkg, idw_ram, idw_sqrt, idw_divider.
module idw_datapath
  import idw_pkg::*;
#(
  parameter int unsigned TableRows = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idw_cmd_t          cmd_i,
  output idw_stat_t         stat_o,
  input  logic              wr_i,
  input  logic [5:0]        row_index_i,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [CoordW-1:0] z_i,
  input  logic [6:0]        rows_cfg_i,
  output logic [CoordW-1:0] interp_o,
  output logic [5:0]        nearest_o
);
  localparam int unsigned AW = $clog2(TableRows);
  localparam int unsigned CW = AW + 1;

  logic [CW-1:0] n_q, rd_q, vl_q;
  logic          vld_q, pass_q;
  logic [CoordW-1:0] xr, yr, zr, qx_q, qy_q;
  logic [CoordW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [SqW-1:0]  bs_q [MaxPick];
  logic [AW-1:0]   bi_q [MaxPick];
  logic [CoordW-1:0] bz_q [MaxPick];
  logic [2:0]      cnt_q, pk_q;
  logic [CoordW-1:0] cx, cy, dx, dy;
  logic [SqW-1:0]  sq;
  logic [DistW-1:0] root;
  logic [NumW-1:0] num_q;
  logic [WeightW+2:0] den_q;
  logic [63:0] dquot;
  logic [5:0] wr_idx;
  logic wr_en;

  assign wr_idx = row_index_i;
  assign wr_en  = wr_i && (32'(wr_idx) < TableRows);

  idw_ram #(.Width(CoordW), .Depth(TableRows)) u_x (.clk_i, .we_i(wr_en),
    .waddr_i(AW'(wr_idx)), .wdata_i(x_i), .raddr_i(rd_q[AW-1:0]), .rdata_o(xr));
  idw_ram #(.Width(CoordW), .Depth(TableRows)) u_y (.clk_i, .we_i(wr_en),
    .waddr_i(AW'(wr_idx)), .wdata_i(y_i), .raddr_i(rd_q[AW-1:0]), .rdata_o(yr));
  idw_ram #(.Width(CoordW), .Depth(TableRows)) u_z (.clk_i, .we_i(wr_en),
    .waddr_i(AW'(wr_idx)), .wdata_i(z_i), .raddr_i(rd_q[AW-1:0]), .rdata_o(zr));

  // clamped query point
  assign cx = (qx_q > xmax_q) ? xmax_q : (qx_q < xmin_q) ? xmin_q : qx_q;
  assign cy = (qy_q > ymax_q) ? ymax_q : (qy_q < ymin_q) ? ymin_q : qy_q;
  assign dx = (cx > xr) ? cx - xr : xr - cx;
  assign dy = (cy > yr) ? cy - yr : yr - cy;
  assign sq = SqW'({24'd0, dx} * {24'd0, dx}) + SqW'({24'd0, dy} * {24'd0, dy});

  logic scanning;
  assign scanning = cmd_i.bounds_step || cmd_i.dist_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rd_q  <= '0;
      n_q   <= CW'(1);
    end else begin
      if (cmd_i.start_query || cmd_i.final_step) begin
        rd_q  <= '0;
        vld_q <= 1'b0;
        if (cmd_i.start_query) begin
          if (rows_cfg_i == 7'd0) n_q <= CW'(1);
          else if ({25'd0, rows_cfg_i} > 32'(TableRows)) n_q <= CW'(TableRows);
          else n_q <= CW'(rows_cfg_i);
        end
      end else if (scanning) begin
        vld_q <= rd_q < n_q;
        if (rd_q < n_q) rd_q <= rd_q + 1'b1;
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vl_q <= rd_q;
    pass_q <= cmd_i.dist_step;
    if (cmd_i.start_query) begin
      qx_q <= x_i;
      qy_q <= y_i;
      cnt_q <= '0;
    end
    if (vld_q && !pass_q) begin
      if (vl_q == '0) begin
        xmin_q <= xr; xmax_q <= xr; ymin_q <= yr; ymax_q <= yr;
      end else begin
        if (xr < xmin_q) xmin_q <= xr;
        if (xr > xmax_q) xmax_q <= xr;
        if (yr < ymin_q) ymin_q <= yr;
        if (yr > ymax_q) ymax_q <= yr;
      end
    end
    if (vld_q && pass_q) begin
      // insert into sorted list of four; strict less keeps lower index first
      if (cnt_q < 3'd4) cnt_q <= cnt_q + 3'd1;
      for (int j = MaxPick - 1; j >= 0; j--) begin
        if (j >= int'(cnt_q) || sq < bs_q[j]) begin
          if (j == 0 || sq >= bs_q[j-1] || (j - 1) >= int'(cnt_q)) begin
            if (j - 1 >= int'(cnt_q) && j != 0) begin
              // slot beyond fill: leave; handled by lower slot
            end else begin
              bs_q[j] <= sq; bi_q[j] <= vl_q[AW-1:0]; bz_q[j] <= zr;
            end
          end else begin
            bs_q[j] <= bs_q[j-1]; bi_q[j] <= bi_q[j-1]; bz_q[j] <= bz_q[j-1];
          end
        end
      end
    end
  end

  // weight phase
  logic [WeightW-1:0] w;
  logic [1:0] psel;
  assign psel = pk_q[1:0];
  assign w = WeightW'(dquot);

  idw_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(cmd_i.sqrt_start), .val_i(bs_q[psel]),
    .done_o(stat_o.sqrt_done), .root_o(root));

  logic [63:0] dnum;
  logic [39:0] dden;
  assign dnum = cmd_i.wdiv_start ? 64'(1) << 36 : 64'(num_q) + 64'(den_q >> 1);
  assign dden = cmd_i.wdiv_start ? 40'(root) : 40'(den_q);

  idw_divider #(.NumBits(64), .DenBits(40)) u_div (.clk_i, .rst_ni,
    .start_i(cmd_i.wdiv_start || cmd_i.div_start), .num_i(dnum), .den_i(dden),
    .done_o(stat_o.div_done), .quot_o(dquot));

  always_ff @(posedge clk_i) begin
    if (cmd_i.final_step) begin
      pk_q <= '0; num_q <= '0; den_q <= '0;
    end else if (cmd_i.accum_step) begin
      num_q <= num_q + NumW'({39'd0, bz_q[psel]} * {26'd0, w});
      den_q <= den_q + (WeightW+3)'(w);
      pk_q  <= pk_q + 3'd1;
    end
  end

  logic [2:0] k;
  assign k = (n_q < CW'(MaxPick)) ? 3'(n_q) : 3'(MaxPick);
  assign stat_o.scan_done = scanning && (rd_q >= n_q) && !vld_q && vl_q != '1;
  assign stat_o.exact     = (bs_q[0] == '0);
  assign stat_o.last_pick = (pk_q + 3'd1 >= k);
  assign interp_o  = stat_o.div_done ? dquot[CoordW-1:0] : bz_q[0];
  assign nearest_o = 6'(bi_q[0]);
endmodule

>>> src/idw_ctrl.sv
// Controller: sequences a query through scans, roots, weights and mean division.
// Depends on idw_pkg.
module idw_ctrl
  import idw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_query_i,
  output logic      in_ready_o,
  output logic      wr_o,
  output idw_cmd_t  cmd_o,
  input  idw_stat_t stat_i,
  output logic      out_load_o,
  output logic      out_exact_o,
  input  logic      out_free_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_BOUNDS, S_GAP, S_DIST, S_CHECK, S_SQRT, S_WDIV, S_ACC, S_MDIV, S_EMIT
  } state_e;
  state_e state_q;
  logic   ex_q, cnt_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign wr_o = in_valid_i && in_ready_o && !in_query_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.start_query = in_valid_i && in_ready_o && in_query_i;
    cmd_o.bounds_step = (state_q == S_BOUNDS);
    cmd_o.dist_step   = (state_q == S_DIST);
    cmd_o.final_step  = (state_q == S_GAP) || (state_q == S_CHECK);
    cmd_o.sqrt_start  = (state_q == S_SQRT) && !cnt_q;
    cmd_o.wdiv_start  = (state_q == S_SQRT) && stat_i.sqrt_done;
    cmd_o.accum_step  = (state_q == S_WDIV) && stat_i.div_done;
    cmd_o.div_start   = (state_q == S_ACC);
  end

  assign out_load_o  = (state_q == S_EMIT) && out_free_i;
  assign out_exact_o = ex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ex_q <= 1'b0;
      cnt_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:   if (cmd_o.start_query) state_q <= S_BOUNDS;
        S_BOUNDS: if (stat_i.scan_done) state_q <= S_GAP;
        S_GAP:    state_q <= S_DIST;
        S_DIST:   if (stat_i.scan_done) state_q <= S_CHECK;
        S_CHECK: begin
          cnt_q <= 1'b0;
          if (stat_i.exact) begin
            ex_q <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            ex_q <= 1'b0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt_q <= 1'b1;
          if (stat_i.sqrt_done) state_q <= S_WDIV;
        end
        S_WDIV: if (stat_i.div_done) begin
          cnt_q <= 1'b0;
          state_q <= stat_i.last_pick ? S_ACC : S_SQRT;
        end
        S_ACC:  state_q <= S_MDIV;
        S_MDIV: if (stat_i.div_done) state_q <= S_EMIT;
        S_EMIT: if (out_free_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.start_query |=> !in_ready_o)
    else $error("ready while query starts");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load_o |-> !in_ready_o)
    else $error("load while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sqrt_start, cmd_o.wdiv_start, cmd_o.div_start}))
    else $error("units started together");
endmodule

>>> src/idw_four_nearest_table_interp_top.sv
// Four-nearest IDW table interpolator, top level. Depends on idw_pkg,
// idw_ctrl and idw_datapath.
// A write transaction (cmd 0) stores one row in a cycle while no query is
// being worked. A query (cmd 1) runs the bounds and distance scans over the
// single-read-port row memories, then one round per chosen row of a square
// root and a weight division, then the mean division; an exact hit skips the
// arithmetic. One query is worked at a time and the input stalls until its
// result is loaded; the result waits in an output register.
module idw_four_nearest_table_interp_top
  import idw_pkg::*;
#(
  parameter int unsigned TABLE_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // row_index, x_value, y_value, z_value
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // interp_value, nearest_index
  output logic        m_axis_tuser,  // exact_hit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data       // rows_in_use
);
  idw_cmd_t  cmd;
  idw_stat_t stat;
  logic wr, load, exact;
  logic [6:0] rows_q;
  logic [23:0] interp;
  logic [5:0] nearest;
  logic ov_q;
  logic [29:0] od_q;
  logic oh_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rows_q <= 7'd1;
    else if (cfg_valid) rows_q <= cfg_data;
  end

  idw_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i(s_axis_tvalid),
    .in_query_i(s_axis_tuser == CMD_QUERY), .in_ready_o(s_axis_tready), .wr_o(wr),
    .cmd_o(cmd), .stat_i(stat), .out_load_o(load), .out_exact_o(exact),
    .out_free_i(!ov_q || m_axis_tready));

  idw_datapath #(.TableRows(TABLE_ROWS)) u_dp (.clk_i, .rst_ni, .cmd_i(cmd),
    .stat_o(stat), .wr_i(wr), .row_index_i(s_axis_tdata[5:0]),
    .x_i(s_axis_tdata[29:6]), .y_i(s_axis_tdata[53:30]), .z_i(s_axis_tdata[77:54]),
    .rows_cfg_i(rows_q), .interp_o(interp), .nearest_o(nearest));

  // hold mean quotient seen at done; exact path takes stored z
  logic [23:0] q_q;
  always_ff @(posedge clk_i) if (stat.div_done) q_q <= interp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (load) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (load) begin
      od_q <= {nearest, exact ? interp : q_q};
      oh_q <= exact;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, od_q};
  assign m_axis_tuser  = oh_q;
endmodule
